// File: rtl/core/alb_pkg.sv
// Package for the ambient light brightness selector.
// Payload structs, filter state type, register map and widths; no dependencies.
package alb_pkg;

    // Width of the smoothed level held in the filter
    localparam int LEVEL_BITS = 10;
    // Field widths of the interface
    localparam int SAMPLE_BITS = 10;
    localparam int BRI_BITS    = 8;
    localparam int LIGHT_BITS  = 10;
    // Signed compare width, wide enough for threshold +/- hysteresis and the level
    localparam int CMP_BITS = ((LEVEL_BITS > LIGHT_BITS) ? LEVEL_BITS : LIGHT_BITS) + 2;

    // Configuration port
    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_THRESHOLD  = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_HYSTERESIS = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_TEST       = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_ALARM      = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_DAY        = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_FLOOR      = 3'd5;

    // Register reset values
    localparam logic [LIGHT_BITS-1:0] THRESHOLD_RST  = 10'd512;
    localparam logic [LIGHT_BITS-1:0] HYSTERESIS_RST = 10'd32;
    localparam logic [BRI_BITS-1:0]   TEST_RST       = 8'd128;
    localparam logic [BRI_BITS-1:0]   ALARM_RST      = 8'd255;
    localparam logic [BRI_BITS-1:0]   DAY_RST        = 8'd64;
    localparam logic [BRI_BITS-1:0]   FLOOR_RST      = 8'd1;

    typedef logic [LEVEL_BITS-1:0] level_t;
    typedef logic [LIGHT_BITS-1:0] light_t;
    typedef logic [BRI_BITS-1:0]   bri_t;

    // Input item
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] light_sample;
        logic                   test_active;
        logic                   alarm_active;
        logic                   link_ok;
        logic                   sock_charging;
        logic                   pulse_present;
    } alb_in_t;

    // Result item
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] smoothed_level;
        logic                   ambient_bright;
        bri_t                   brightness;
    } alb_out_t;

    // Filter state carried from item to item
    typedef struct packed {
        level_t level;
        logic   bright;
    } alb_state_t;

    // Brightness registers never drive zero
    function automatic bri_t clamp_bri(input bri_t v);
        return (v == '0) ? bri_t'(1) : v;
    endfunction

endpackage

// File: rtl/core/alb_filter.sv
// Smoothing filter and bright-ambient hysteresis for one sample.
// Pure combinational next-state logic; depends on alb_pkg.
module alb_filter (
    input  alb_pkg::alb_state_t state_cur,
    input  alb_pkg::level_t     sample,
    input  alb_pkg::light_t     threshold,
    input  alb_pkg::light_t     hysteresis,
    output alb_pkg::alb_state_t state_nxt
);
    import alb_pkg::*;

    logic [LEVEL_BITS+2:0] acc;
    level_t                level_new;
    logic signed [CMP_BITS-1:0] lvl_s;
    logic signed [CMP_BITS-1:0] hi_s;
    logic signed [CMP_BITS-1:0] lo_s;

    // 7*level + sample, then divide by 8
    always_comb begin
        acc = {state_cur.level, 3'b000} - (LEVEL_BITS+3)'(state_cur.level)
              + (LEVEL_BITS+3)'(sample);
        if (state_cur.level == '0) begin
            level_new = sample;
        end else begin
            level_new = acc[LEVEL_BITS+2:3];
        end
    end

    // Band edges, signed so the low edge may go negative
    always_comb begin
        lvl_s = signed'(CMP_BITS'(level_new));
        hi_s  = signed'(CMP_BITS'(threshold)) + signed'(CMP_BITS'(hysteresis));
        lo_s  = signed'(CMP_BITS'(threshold)) - signed'(CMP_BITS'(hysteresis));
    end

    // Hysteresis flag
    always_comb begin
        state_nxt.level  = level_new;
        state_nxt.bright = state_cur.bright;
        if (!state_cur.bright && (lvl_s > hi_s)) begin
            state_nxt.bright = 1'b1;
        end else if (state_cur.bright && (lvl_s < lo_s)) begin
            state_nxt.bright = 1'b0;
        end
    end

endmodule

// File: rtl/core/ambient_light_brightness_select.sv
// Top level of the ambient light brightness selector.
// Uses alb_pkg and alb_filter.
//
// Takes one item per clock unless the result stalls: each light sample with
// its status flags updates a smoothed level ((7*level+sample)/8, seeded from
// the sample while the level is zero) and a bright-ambient flag with a
// hysteresis band, and yields one result with the level, the flag and the
// brightness picked by priority (test, alarm, day when link is up, not
// charging, pulse present and bright, else floor), each clamped to 1..255.
// Items pass through an input register and a result register, with the
// filter, compare and selection between them; the level and flag recurrence
// closes within that one stage, so the sustained rate is one item per cycle
// while m_ready stays high. Configuration registers sit on an APB port at
// byte addresses 4*i and should be written while no item is in flight.
module ambient_light_brightness_select (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  alb_pkg::alb_in_t                  s_data,
    // result items
    output logic                              m_valid,
    input  logic                              m_ready,
    output alb_pkg::alb_out_t                 m_data,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [alb_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [alb_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [alb_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);
    import alb_pkg::*;

    light_t threshold_reg;
    light_t hysteresis_reg;
    bri_t   test_reg;
    bri_t   alarm_reg;
    bri_t   day_reg;
    bri_t   floor_reg;

    logic       in_valid_reg;
    alb_in_t    in_data_reg;
    logic       out_valid_reg;
    alb_out_t   out_data_reg;
    alb_state_t state_reg;
    alb_state_t state_next;

    logic                    advance;
    logic                    cfg_wr;
    logic [REG_IDX_BITS-1:0] reg_idx;
    bri_t                    bri_next;
    alb_out_t                out_data_next;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[APB_ADDR_BITS-1:2];

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg  <= THRESHOLD_RST;
            hysteresis_reg <= HYSTERESIS_RST;
            test_reg       <= TEST_RST;
            alarm_reg      <= ALARM_RST;
            day_reg        <= DAY_RST;
            floor_reg      <= FLOOR_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_THRESHOLD:  threshold_reg  <= pwdata[LIGHT_BITS-1:0];
                REG_HYSTERESIS: hysteresis_reg <= pwdata[LIGHT_BITS-1:0];
                REG_TEST:       test_reg       <= pwdata[BRI_BITS-1:0];
                REG_ALARM:      alarm_reg      <= pwdata[BRI_BITS-1:0];
                REG_DAY:        day_reg        <= pwdata[BRI_BITS-1:0];
                REG_FLOOR:      floor_reg      <= pwdata[BRI_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            REG_THRESHOLD:  prdata = APB_DATA_BITS'(threshold_reg);
            REG_HYSTERESIS: prdata = APB_DATA_BITS'(hysteresis_reg);
            REG_TEST:       prdata = APB_DATA_BITS'(test_reg);
            REG_ALARM:      prdata = APB_DATA_BITS'(alarm_reg);
            REG_DAY:        prdata = APB_DATA_BITS'(day_reg);
            REG_FLOOR:      prdata = APB_DATA_BITS'(floor_reg);
            default:        prdata = '0;
        endcase
    end

    // Pipeline flow: the held item moves on when the result slot is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    alb_filter u_filter (
        .state_cur  (state_reg),
        .sample     (level_t'(in_data_reg.light_sample)),
        .threshold  (threshold_reg),
        .hysteresis (hysteresis_reg),
        .state_nxt  (state_next)
    );

    // Brightness by priority
    always_comb begin
        if (in_data_reg.test_active) begin
            bri_next = clamp_bri(test_reg);
        end else if (in_data_reg.alarm_active) begin
            bri_next = clamp_bri(alarm_reg);
        end else if (in_data_reg.link_ok && !in_data_reg.sock_charging &&
                     in_data_reg.pulse_present && state_next.bright) begin
            bri_next = clamp_bri(day_reg);
        end else begin
            bri_next = clamp_bri(floor_reg);
        end
        out_data_next.smoothed_level = SAMPLE_BITS'(state_next.level);
        out_data_next.ambient_bright = state_next.bright;
        out_data_next.brightness     = bri_next;
    end

    // Control and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// File: rtl/core/alb_checker.sv
// Port-level checks for the ambient light brightness selector.
// Depends on alb_pkg; bound to ambient_light_brightness_select below.
module alb_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input alb_pkg::alb_out_t m_data,
    input logic              pready
);
    import alb_pkg::*;

    // Brightness is clamped, so a result never carries zero
    a_bri_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.brightness != '0))
        else $error("result brightness is zero");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed or dropped");

    // No result right after a reset cycle
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Configuration port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind ambient_light_brightness_select alb_checker u_alb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);
